@@ hdl/assert_macros.svh @@
// Assertion macros shared by the blit engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define BBE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define BBE_ASSERT_NEXT(lbl, pre, post, msg) \
    `BBE_ASSERT(lbl, (pre) |=> (post), msg)

`endif

@@ hdl/bbe_pkg.sv @@
// Types, register indexes and helper functions of the blit engine.
package bbe_pkg;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_SRC_W    = 3'd2;
    localparam logic [2:0] REG_SRC_H    = 3'd3;
    localparam logic [2:0] REG_DST_W    = 3'd4;
    localparam logic [2:0] REG_DST_H    = 3'd5;
    localparam logic [2:0] REG_TINT     = 3'd6;
    localparam logic [2:0] REG_MODE     = 3'd7;

    localparam int MODE_BLEND    = 0;
    localparam int MODE_TINT     = 1;
    localparam int MODE_TEXTURED = 2;

    localparam logic [12:0] MAX_DST = 13'd4096;

    typedef logic [3:0][7:0] rgba_t;

    typedef struct packed {
        logic [5:0]  origin_x;
        logic [5:0]  origin_y;
        logic [6:0]  src_w;
        logic [6:0]  src_h;
        logic [12:0] dst_w;
        logic [12:0] dst_h;
        rgba_t       tint;
        logic [2:0]  mode;
    } cfg_t;

    typedef struct packed {
        logic        is_pixel;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [31:0] rgba;
    } item_t;

    // Destination size with zero taken as one and large values clamped.
    function automatic logic [12:0] eff_dim(input logic [12:0] d);
        logic [12:0] r;
        r = d;
        if (d == 13'd0) r = 13'd1;
        else if (d > MAX_DST) r = MAX_DST;
        return r;
    endfunction

    // Remainder of a small coordinate against the texture size.
    function automatic logic [7:0] tex_wrap(input logic [7:0] v, input int unsigned lim);
        int unsigned r;
        r = 32'(v);
        for (int k = 7; k >= 0; k--) begin
            if (r >= (lim << k)) r = r - (lim << k);
        end
        return r[7:0];
    endfunction

endpackage

@@ hdl/bilinear_blit_blend_engine_top.sv @@
// Top level of the bilinear blit and blend engine.
//
// The block scales a source rectangle of its texture store onto a destination
// rectangle, with optional tint and premultiplied-alpha blend, or fills with a
// solid color. A load transaction (tuser 0) writes one texel. A pixel
// transaction (tuser 1) carries the existing destination pixel and yields the
// new pixel in raster order, tlast on the final pixel of the rectangle. A
// textured pixel makes four reads from the single-port texture memory, then
// passes the horizontal and vertical interpolation, tint and blend stages. A
// fill pixel passes the tint and blend stages only. On the first pixel of each
// rectangle a one-bit-per-cycle divider first computes the step sizes. A
// two-entry queue decouples input acceptance from execution, and a result
// register lets the next item start while an earlier result waits. Any
// configuration write restarts the rectangle; write configuration only while
// the block is idle. The texture store is not cleared at reset.
module bilinear_blit_blend_engine_top import bbe_pkg::*; #(
    parameter int TEX_WIDTH  = 64,
    parameter int TEX_HEIGHT = 64,
    parameter int FRAC_BITS  = 18
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // tex_col[5:0], tex_row[11:6], rgba_value[43:12]
    input  logic        s_axis_tuser,  // op: 0 load texel, 1 process pixel
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_rgba[31:0]
    output logic        m_axis_tlast,  // last_pixel
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  q_valid, q_pop;
    item_t q_item;

    // Configuration is always accepted; each register keeps its low bits.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x <= 6'd0;
            cfg_reg.origin_y <= 6'd0;
            cfg_reg.src_w    <= 7'd1;
            cfg_reg.src_h    <= 7'd1;
            cfg_reg.dst_w    <= 13'd1;
            cfg_reg.dst_h    <= 13'd1;
            cfg_reg.tint     <= 32'hFFFF_FFFF;
            cfg_reg.mode     <= 3'd4;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ORIGIN_X: cfg_reg.origin_x <= cfg_data[5:0];
                REG_ORIGIN_Y: cfg_reg.origin_y <= cfg_data[5:0];
                REG_SRC_W:    cfg_reg.src_w    <= cfg_data[6:0];
                REG_SRC_H:    cfg_reg.src_h    <= cfg_data[6:0];
                REG_DST_W:    cfg_reg.dst_w    <= cfg_data[12:0];
                REG_DST_H:    cfg_reg.dst_h    <= cfg_data[12:0];
                REG_TINT:     cfg_reg.tint     <= cfg_data;
                REG_MODE:     cfg_reg.mode     <= cfg_data[2:0];
                default:      cfg_reg.mode     <= cfg_reg.mode;
            endcase
        end
    end

    // The front end decodes each transaction and queues it.
    bbe_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    // The back end executes loads and pixels in order.
    bbe_back #(
        .TEX_WIDTH(TEX_WIDTH), .TEX_HEIGHT(TEX_HEIGHT), .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg(cfg_reg), .cfg_wr(cfg_valid),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_tdata(m_axis_tdata), .m_tlast(m_axis_tlast)
    );

endmodule

@@ hdl/bbe_front.sv @@
// Input side: takes stream transactions, decodes them and queues them.
`include "assert_macros.svh"
module bbe_front import bbe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tuser,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    item_t      dec;

    always_comb begin
        dec.is_pixel = s_tuser;
        dec.col      = s_tdata[5:0];
        dec.row      = s_tdata[11:6];
        dec.rgba     = s_tdata[43:12];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wr_ptr_reg] <= dec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !q_pop) count_reg <= count_reg + 2'd1;
            else if (q_pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

    `BBE_ASSERT_NEXT(a_fill_tracks, push && !q_pop, count_reg == $past(count_reg) + 2'd1, "queue count lost a push")

endmodule

@@ hdl/bbe_div.sv @@
// Restoring divider, one quotient bit per cycle.
module bbe_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg, quo_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    always_comb begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        ge       = (trial >= {1'b0, den});
        rem_next = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

@@ hdl/bbe_back.sv @@
// Execution side: texture store, stepping, bilinear sample, tint, blend and output.
`include "assert_macros.svh"
module bbe_back import bbe_pkg::*; #(
    parameter int TEX_WIDTH  = 64,
    parameter int TEX_HEIGHT = 64,
    parameter int FRAC_BITS  = 18
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        cfg_wr,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    localparam int POS_W = FRAC_BITS + 7;
    localparam int DEPTH = TEX_WIDTH * TEX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_A0   = 4'd2;
    localparam logic [3:0] S_A1   = 4'd3;
    localparam logic [3:0] S_A2   = 4'd4;
    localparam logic [3:0] S_A3   = 4'd5;
    localparam logic [3:0] S_A4   = 4'd6;
    localparam logic [3:0] S_H    = 4'd7;
    localparam logic [3:0] S_V    = 4'd8;
    localparam logic [3:0] S_TN   = 4'd9;
    localparam logic [3:0] S_BL   = 4'd10;

    logic [3:0]       state_reg;
    logic [POS_W-1:0] pos_x_reg, pos_y_reg, step_x_reg, step_y_reg;
    logic [11:0]      col_reg, row_reg;
    logic [31:0]      dst_pix_reg;
    rgba_t            t00_reg, t10_reg, t01_reg, t11_reg;
    rgba_t            r0_reg, r1_reg, c_reg;
    rgba_t            r0_next, r1_next, cv_next, ct_next, res;
    logic             out_valid_reg, out_last_reg;
    logic [31:0]      out_data_reg;

    logic [31:0]      tex_mem [DEPTH];
    logic [31:0]      rd_data_reg;
    logic [AW-1:0]    mem_addr;
    logic             mem_we;

    logic [12:0]      dw, dh;
    logic             scale, textured;
    logic [POS_W-1:0] org_x, org_y, qx, qy;
    logic             div_start, busy_x, busy_y, div_busy;
    logic [7:0]       x0, x1, y0, y1;
    logic [FRAC_BITS-1:0] fx, fy;
    logic             bl_fire, col_end, row_end;
    logic             rect_done, out_held;

    function automatic logic [AW-1:0] tex_addr(input logic [7:0] r, input logic [7:0] c);
        return AW'(32'(r) * 32'(TEX_WIDTH) + 32'(c));
    endfunction

    assign dw       = eff_dim(cfg.dst_w);
    assign dh       = eff_dim(cfg.dst_h);
    assign scale    = ({6'd0, cfg.src_w} != dw) || ({6'd0, cfg.src_h} != dh);
    assign textured = cfg.mode[MODE_TEXTURED];
    assign org_x    = POS_W'({cfg.origin_x, {FRAC_BITS{1'b0}}});
    assign org_y    = POS_W'({cfg.origin_y, {FRAC_BITS{1'b0}}});

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign mem_we    = q_pop && !q_item.is_pixel;
    assign div_start = q_pop && q_item.is_pixel && (col_reg == 12'd0) && (row_reg == 12'd0);
    assign div_busy  = busy_x || busy_y;

    bbe_div #(.NUM_W(POS_W), .DEN_W(13)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num({cfg.src_w, {FRAC_BITS{1'b0}}}), .den(dw), .busy(busy_x), .quo(qx)
    );
    bbe_div #(.NUM_W(POS_W), .DEN_W(13)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num({cfg.src_h, {FRAC_BITS{1'b0}}}), .den(dh), .busy(busy_y), .quo(qy)
    );

    // Sample coordinates and their right and lower neighbors.
    always_comb begin
        x0 = tex_wrap({1'b0, pos_x_reg[POS_W-1 -: 7]}, TEX_WIDTH);
        x1 = tex_wrap({1'b0, pos_x_reg[POS_W-1 -: 7]} + 8'd1, TEX_WIDTH);
        y0 = tex_wrap({1'b0, pos_y_reg[POS_W-1 -: 7]}, TEX_HEIGHT);
        y1 = tex_wrap({1'b0, pos_y_reg[POS_W-1 -: 7]} + 8'd1, TEX_HEIGHT);
        fx = pos_x_reg[FRAC_BITS-1:0];
        fy = pos_y_reg[FRAC_BITS-1:0];
    end

    always_comb begin
        unique case (state_reg)
            S_A0:    mem_addr = tex_addr(y0, x0);
            S_A1:    mem_addr = tex_addr(y0, x1);
            S_A2:    mem_addr = tex_addr(y1, x0);
            S_A3:    mem_addr = tex_addr(y1, x1);
            default: mem_addr = tex_addr(tex_wrap({2'b0, q_item.row}, TEX_HEIGHT),
                                         tex_wrap({2'b0, q_item.col}, TEX_WIDTH));
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) tex_mem[mem_addr] <= q_item.rgba;
        rd_data_reg <= tex_mem[mem_addr];
    end

    // Horizontal interpolation; the arithmetic shift gives the floor.
    always_comb begin
        logic signed [9:0]           d0, d1, s0, s1, u0, u1;
        logic signed [FRAC_BITS+10:0] p0, p1;
        for (int k = 0; k < 4; k++) begin
            d0 = $signed({2'b0, t10_reg[k]}) - $signed({2'b0, t00_reg[k]});
            d1 = $signed({2'b0, t11_reg[k]}) - $signed({2'b0, t01_reg[k]});
            p0 = d0 * $signed({1'b0, fx});
            p1 = d1 * $signed({1'b0, fx});
            s0 = 10'(p0 >>> FRAC_BITS);
            s1 = 10'(p1 >>> FRAC_BITS);
            u0 = $signed({2'b0, t00_reg[k]}) + s0;
            u1 = $signed({2'b0, t01_reg[k]}) + s1;
            r0_next[k] = u0[7:0];
            r1_next[k] = u1[7:0];
        end
    end

    // Vertical interpolation.
    always_comb begin
        logic signed [9:0]           d, s, u;
        logic signed [FRAC_BITS+10:0] p;
        for (int k = 0; k < 4; k++) begin
            d = $signed({2'b0, r1_reg[k]}) - $signed({2'b0, r0_reg[k]});
            p = d * $signed({1'b0, fy});
            s = 10'(p >>> FRAC_BITS);
            u = $signed({2'b0, r0_reg[k]}) + s;
            cv_next[k] = u[7:0];
        end
    end

    // Tint, or the fill color when untextured.
    always_comb begin
        logic [8:0]  t;
        logic [16:0] p;
        for (int k = 0; k < 4; k++) begin
            t = {1'b0, cfg.tint[k]} + {8'd0, (k == 3) && scale};
            p = {9'd0, c_reg[k]} * {8'd0, t};
            if (!textured) ct_next[k] = cfg.tint[k];
            else if (cfg.mode[MODE_TINT]) ct_next[k] = p[15:8];
            else ct_next[k] = c_reg[k];
        end
    end

    // Premultiplied blend over the destination pixel, saturated, when blend mode is set.
    always_comb begin
        logic [7:0]  inv;
        logic [15:0] p;
        logic [8:0]  v;
        rgba_t       d;
        d   = dst_pix_reg;
        inv = 8'd255 - c_reg[3];
        for (int k = 0; k < 4; k++) begin
            p = {8'd0, d[k]} * {8'd0, inv};
            v = {1'b0, c_reg[k]} + {1'b0, p[15:8]};
            if (!cfg.mode[MODE_BLEND]) res[k] = c_reg[k];
            else res[k] = v[8] ? 8'd255 : v[7:0];
        end
    end

    assign bl_fire   = (state_reg == S_BL) && (!out_valid_reg || m_tready);
    assign col_end   = ({1'b0, col_reg} + 13'd1) >= dw;
    assign row_end   = ({1'b0, row_reg} + 13'd1) >= dh;
    assign rect_done = bl_fire && col_end && row_end;
    assign out_held  = (state_reg == S_BL) && out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop && q_item.is_pixel) begin
                        dst_pix_reg <= q_item.rgba;
                        if (div_start) begin
                            pos_x_reg <= org_x;
                            pos_y_reg <= org_y;
                            state_reg <= S_DIV;
                        end else begin
                            state_reg <= textured ? S_A0 : S_TN;
                        end
                    end
                end
                S_DIV: begin
                    if (!div_busy) begin
                        step_x_reg <= qx;
                        step_y_reg <= qy;
                        state_reg  <= textured ? S_A0 : S_TN;
                    end
                end
                S_A0: state_reg <= S_A1;
                S_A1: begin t00_reg <= rd_data_reg; state_reg <= S_A2; end
                S_A2: begin t10_reg <= rd_data_reg; state_reg <= S_A3; end
                S_A3: begin t01_reg <= rd_data_reg; state_reg <= S_A4; end
                S_A4: begin t11_reg <= rd_data_reg; state_reg <= S_H; end
                S_H: begin
                    r0_reg    <= r0_next;
                    r1_reg    <= r1_next;
                    state_reg <= S_V;
                end
                S_V: begin c_reg <= cv_next; state_reg <= S_TN; end
                S_TN: begin c_reg <= ct_next; state_reg <= S_BL; end
                S_BL: begin
                    if (bl_fire) begin
                        out_data_reg <= res;
                        out_last_reg <= col_end && row_end;
                        if (col_end) begin
                            pos_x_reg <= org_x;
                            pos_y_reg <= pos_y_reg + step_y_reg;
                        end else begin
                            pos_x_reg <= pos_x_reg + step_x_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            // The result register fills on a finished pixel and empties when taken.
            if (bl_fire) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;

            // Any register write restarts the rectangle.
            if (cfg_wr) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (bl_fire) begin
                if (col_end) begin
                    col_reg <= '0;
                    row_reg <= row_end ? 12'd0 : row_reg + 12'd1;
                end else begin
                    col_reg <= col_reg + 12'd1;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `BBE_ASSERT(a_div_in_div, div_busy |-> state_reg == S_DIV, "divider busy outside S_DIV")
    `BBE_ASSERT_NEXT(a_last_restarts, rect_done, (col_reg | row_reg) == '0, "no restart")
    `BBE_ASSERT_NEXT(a_blend_waits, out_held && !m_tready, out_held, "result dropped")

endmodule
